>>> rtl/tlbl_pkg.sv
// Package with shared types, constants and helpers for the tree ancestor engine.
package tlbl_pkg;

  localparam int MaxNodes = 1024;
  localparam int NodeW    = 10;
  localparam int Levels   = 11;
  localparam int LevW     = 4;
  localparam int EdgeCap  = 2048;
  localparam int EdgeAw   = 11;
  localparam int TotalW   = 12;
  localparam int DepthW   = 11;
  localparam int LiftW    = 11;
  localparam int NcW      = 11;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_BUILD = 2'd2,
    KIND_QUERY = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_UNBUILT = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, B_CLR, B_DEQ, B_DEQW, B_EREAD, B_ECHK, B_SIDE, B_UVIS, B_VROW,
    B_JRD, B_JGET, B_WR, Q_RA, Q_RB, Q_CMP, Q_AFTERB, Q_LOOP, Q_MA, Q_MB,
    Q_FIN, L_SCAN, L_USE, S_DONE
  } fsm_e;

  typedef struct packed {
    logic                               visited;
    logic [DepthW-1:0]                  depth;
    logic [Levels-1:0][NodeW-1:0]       jump;
  } node_row_t;

  typedef struct packed {
    logic              re;
    logic [NodeW-1:0]  raddr;
    logic              we;
    logic [NodeW-1:0]  waddr;
    node_row_t         wdata;
  } node_req_t;

  typedef struct packed {
    logic [NodeW-1:0] a;
    logic [NodeW-1:0] b;
  } link_t;

  typedef struct packed {
    link_t            lnk;
    logic [NodeW-1:0] queue;
  } edge_row_t;

  typedef struct packed {
    logic              re;
    logic [EdgeAw-1:0] raddr;
    logic              we_link;
    logic              we_queue;
    logic [EdgeAw-1:0] waddr;
    link_t             link_wdata;
    logic [NodeW-1:0]  queue_wdata;
  } edge_req_t;

  // Index of the lowest set bit of a lift amount.
  function automatic logic [LevW-1:0] lowest_bit(logic [LiftW-1:0] k);
    logic [LevW-1:0] idx;
    idx = '0;
    for (int i = LiftW - 1; i >= 0; i--) begin
      if (k[i]) begin
        idx = LevW'(i);
      end
    end
    return idx;
  endfunction

endpackage

>>> rtl/tlbl_node_mem.sv
// Node table memory: visited flag, depth and ancestor jumps per node.
module tlbl_node_mem (
  input  logic                clk_i,
  input  tlbl_pkg::node_req_t req_i,
  output tlbl_pkg::node_row_t rdata_o
);
  import tlbl_pkg::*;

  node_row_t mem [MaxNodes];
  node_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tlbl_edge_mem.sv
// Edge store memory, with the breadth-first queue kept in a second field.
module tlbl_edge_mem (
  input  logic                clk_i,
  input  tlbl_pkg::edge_req_t req_i,
  output tlbl_pkg::edge_row_t rdata_o
);
  import tlbl_pkg::*;

  edge_row_t mem [EdgeCap];
  edge_row_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we_link) begin
      mem[req_i.waddr].lnk <= req_i.link_wdata;
    end
    if (req_i.we_queue) begin
      mem[req_i.waddr].queue <= req_i.queue_wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tree_lca_binary_lifting.sv
// Lowest common ancestor engine: edge store, breadth-first table build, lifting query.
// Items are handled one at a time. Clear and add are done when accepted; an error query
// goes straight to the done state. A build sweeps 1024 node rows, then dequeues each
// queued node, checks both ends of every stored edge, and fills the jump rows of each
// new node level by level. A query reads both depths, lifts the deeper node, then runs
// up to ceil(log2(n_act+1)) search steps. Reset is asynchronous: edges and built flag clear.
module tree_lca_binary_lifting (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [10:0]               cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic [9:0]                node_a_i,
  input  logic [9:0]                node_b_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [9:0]                ancestor_o,
  output logic [1:0]                status_o
);
  import tlbl_pkg::*;

  fsm_e               state_q, state_d, ret_q, ret_d;
  logic [NcW-1:0]     node_count_q, node_count_d;
  logic [TotalW-1:0]  edge_total_q, edge_total_d;
  logic               built_q, built_d;
  logic               out_valid_q, out_valid_d;
  logic [NodeW-1:0]   anc_q, anc_d;
  status_e            st_q, st_d;
  logic [NodeW-1:0]   res_anc_q, res_anc_d;
  status_e            res_st_q, res_st_d;
  logic [NodeW-1:0]   cnt_q, cnt_d;
  logic [NcW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [TotalW-1:0]  e_q, e_d;
  logic [NodeW-1:0]   v_q, v_d, u_q, u_d;
  logic               side_q, side_d;
  link_t              lnk_q, lnk_d;
  node_row_t          row_q, row_d;
  logic [LevW-1:0]    j_q, j_d;
  logic [NodeW-1:0]   qa_q, qa_d, qb_q, qb_d, lv_q, lv_d, la_q, la_d;
  logic [DepthW-1:0]  da_q, da_d;
  logic [NcW-1:0]     lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [LiftW-1:0]   k_q, k_d;

  node_req_t          nreq;
  node_row_t          nrd;
  edge_req_t          ereq;
  edge_row_t          erd;

  logic               accept;
  logic [NcW-1:0]     n_act;
  logic               range_err;
  logic               hit;
  logic [NodeW-1:0]   hit_node;
  logic [NcW:0]       mid_sum;

  tlbl_node_mem u_node_mem (.clk_i(clk_i), .req_i(nreq), .rdata_o(nrd));
  tlbl_edge_mem u_edge_mem (.clk_i(clk_i), .req_i(ereq), .rdata_o(erd));

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign ancestor_o  = anc_q;
  assign status_o    = st_q;

  always_comb begin
    if (node_count_q == '0) begin
      n_act = NcW'(1);
    end else if (node_count_q > NcW'(MaxNodes)) begin
      n_act = NcW'(MaxNodes);
    end else begin
      n_act = node_count_q;
    end
  end

  assign range_err = ({1'b0, node_a_i} >= n_act) || ({1'b0, node_b_i} >= n_act);
  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};

  // An edge side matches when its near end is the node being expanded and its far end is in range.
  always_comb begin
    if (!side_q) begin
      hit      = (lnk_q.a == v_q) && ({1'b0, lnk_q.b} < n_act);
      hit_node = lnk_q.b;
    end else begin
      hit      = (lnk_q.b == v_q) && ({1'b0, lnk_q.a} < n_act);
      hit_node = lnk_q.a;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_e'(kind_i) == KIND_BUILD) begin
            state_d = B_CLR;
          end else if (kind_e'(kind_i) == KIND_QUERY) begin
            state_d = (range_err || !built_q) ? S_DONE : Q_RA;
          end
        end
      end
      B_CLR:    if (cnt_q == '1) state_d = B_DEQ;
      B_DEQ:    state_d = (head_q == tail_q) ? S_IDLE : B_DEQW;
      B_DEQW:   state_d = B_EREAD;
      B_EREAD:  state_d = (e_q == edge_total_q) ? B_DEQ : B_ECHK;
      B_ECHK:   state_d = B_SIDE;
      B_SIDE: begin
        if (hit) begin
          state_d = B_UVIS;
        end else begin
          state_d = side_q ? B_EREAD : B_SIDE;
        end
      end
      B_UVIS: begin
        if (nrd.visited) begin
          state_d = side_q ? B_EREAD : B_SIDE;
        end else begin
          state_d = B_VROW;
        end
      end
      B_VROW:   state_d = B_JRD;
      B_JRD:    state_d = (j_q == LevW'(Levels)) ? B_WR : B_JGET;
      B_JGET:   state_d = B_JRD;
      B_WR:     state_d = side_q ? B_EREAD : B_SIDE;
      Q_RA:     state_d = Q_RB;
      Q_RB:     state_d = Q_CMP;
      Q_CMP:    state_d = L_SCAN;
      Q_AFTERB: state_d = Q_LOOP;
      Q_LOOP:   state_d = L_SCAN;
      Q_MA:     state_d = L_SCAN;
      Q_MB:     state_d = Q_LOOP;
      Q_FIN:    state_d = S_DONE;
      L_SCAN:   state_d = (k_q == '0) ? ret_q : L_USE;
      L_USE:    state_d = L_SCAN;
      S_DONE:   if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath updates and memory requests.
  always_comb begin
    node_count_d = cfg_we_i ? cfg_wdata_i : node_count_q;
    edge_total_d = edge_total_q;
    built_d      = built_q;
    out_valid_d  = out_valid_q;
    anc_d        = anc_q;
    st_d         = st_q;
    res_anc_d    = res_anc_q;
    res_st_d     = res_st_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    tail_d       = tail_q;
    e_d          = e_q;
    v_d          = v_q;
    u_d          = u_q;
    side_d       = side_q;
    lnk_d        = lnk_q;
    row_d        = row_q;
    j_d          = j_q;
    qa_d         = qa_q;
    qb_d         = qb_q;
    lv_d         = lv_q;
    la_d         = la_q;
    da_d         = da_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    k_d          = k_q;
    ret_d        = ret_q;
    nreq         = '0;
    ereq         = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (kind_e'(kind_i))
            KIND_CLEAR: edge_total_d = '0;
            KIND_ADD: begin
              if (edge_total_q < TotalW'(EdgeCap)) begin
                ereq.we_link    = 1'b1;
                ereq.waddr      = edge_total_q[EdgeAw-1:0];
                ereq.link_wdata = '{a: node_a_i, b: node_b_i};
                edge_total_d    = edge_total_q + TotalW'(1);
              end
            end
            KIND_BUILD: cnt_d = '0;
            KIND_QUERY: begin
              qa_d      = node_a_i;
              qb_d      = node_b_i;
              res_anc_d = '0;
              if (range_err) begin
                res_st_d = ST_RANGE;
              end else begin
                res_st_d = ST_UNBUILT;
              end
            end
            default: ;
          endcase
        end
      end
      B_CLR: begin
        // Sweep every node row; the root row and queue head go in when the sweep is at row 0.
        nreq.we    = 1'b1;
        nreq.waddr = cnt_q;
        nreq.wdata = '0;
        if (cnt_q == '0) begin
          nreq.wdata.visited = 1'b1;
          nreq.wdata.depth   = DepthW'(1);
          ereq.we_queue      = 1'b1;
          ereq.waddr         = '0;
          ereq.queue_wdata   = '0;
        end
        cnt_d  = cnt_q + NodeW'(1);
        head_d = '0;
        tail_d = NcW'(1);
      end
      B_DEQ: begin
        if (head_q == tail_q) begin
          built_d = 1'b1;
        end else begin
          ereq.re    = 1'b1;
          ereq.raddr = {1'b0, head_q[NodeW-1:0]};
        end
      end
      B_DEQW: begin
        v_d    = erd.queue;
        head_d = head_q + NcW'(1);
        e_d    = '0;
      end
      B_EREAD: begin
        if (e_q != edge_total_q) begin
          ereq.re    = 1'b1;
          ereq.raddr = e_q[EdgeAw-1:0];
        end
      end
      B_ECHK: begin
        lnk_d  = erd.lnk;
        side_d = 1'b0;
      end
      B_SIDE: begin
        if (hit) begin
          u_d        = hit_node;
          nreq.re    = 1'b1;
          nreq.raddr = hit_node;
        end else if (side_q) begin
          side_d = 1'b0;
          e_d    = e_q + TotalW'(1);
        end else begin
          side_d = 1'b1;
        end
      end
      B_UVIS: begin
        if (nrd.visited) begin
          if (side_q) begin
            side_d = 1'b0;
            e_d    = e_q + TotalW'(1);
          end else begin
            side_d = 1'b1;
          end
        end else begin
          nreq.re    = 1'b1;
          nreq.raddr = v_q;
        end
      end
      B_VROW: begin
        row_d         = '0;
        row_d.visited = 1'b1;
        row_d.depth   = nrd.depth + DepthW'(1);
        row_d.jump[0] = v_q;
        j_d           = LevW'(1);
      end
      B_JRD: begin
        if (j_q != LevW'(Levels)) begin
          nreq.re    = 1'b1;
          nreq.raddr = row_q.jump[j_q - LevW'(1)];
        end
      end
      B_JGET: begin
        row_d.jump[j_q] = nrd.jump[j_q - LevW'(1)];
        j_d             = j_q + LevW'(1);
      end
      B_WR: begin
        nreq.we    = 1'b1;
        nreq.waddr = u_q;
        nreq.wdata = row_q;
        if (tail_q < NcW'(MaxNodes)) begin
          ereq.we_queue    = 1'b1;
          ereq.waddr       = EdgeAw'(tail_q);
          ereq.queue_wdata = u_q;
          tail_d           = tail_q + NcW'(1);
        end
        if (side_q) begin
          side_d = 1'b0;
          e_d    = e_q + TotalW'(1);
        end else begin
          side_d = 1'b1;
        end
      end
      Q_RA: begin
        nreq.re    = 1'b1;
        nreq.raddr = qa_q;
      end
      Q_RB: begin
        da_d       = nrd.depth;
        nreq.re    = 1'b1;
        nreq.raddr = qb_q;
      end
      Q_CMP: begin
        // The deeper node is lifted to the depth of the other one.
        if (da_q > nrd.depth) begin
          qa_d = qb_q;
          qb_d = qa_q;
          lv_d = qa_q;
          k_d  = da_q - nrd.depth;
        end else begin
          lv_d = qb_q;
          k_d  = nrd.depth - da_q;
        end
        ret_d = Q_AFTERB;
      end
      Q_AFTERB: begin
        qb_d = lv_q;
        lo_d = '0;
        hi_d = n_act;
      end
      Q_LOOP: begin
        lv_d = qa_q;
        if (lo_q < hi_q) begin
          mid_d = mid_sum[NcW:1];
          k_d   = mid_sum[NcW:1];
          ret_d = Q_MA;
        end else begin
          k_d   = lo_q;
          ret_d = Q_FIN;
        end
      end
      Q_MA: begin
        la_d  = lv_q;
        lv_d  = qb_q;
        k_d   = mid_q;
        ret_d = Q_MB;
      end
      Q_MB: begin
        if (la_q == lv_q) begin
          hi_d = mid_q;
        end else begin
          lo_d = mid_q + NcW'(1);
        end
      end
      Q_FIN: begin
        res_anc_d = lv_q;
        res_st_d  = ST_OK;
      end
      L_SCAN: begin
        if (k_q != '0) begin
          nreq.re    = 1'b1;
          nreq.raddr = lv_q;
        end
      end
      L_USE: begin
        lv_d = nrd.jump[lowest_bit(k_q)];
        k_d  = k_q & (k_q - LiftW'(1));
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          anc_d       = res_anc_q;
          st_d        = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      node_count_q <= NcW'(MaxNodes);
      edge_total_q <= '0;
      built_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      node_count_q <= node_count_d;
      edge_total_q <= edge_total_d;
      built_q      <= built_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q     <= ret_d;
    anc_q     <= anc_d;
    st_q      <= st_d;
    res_anc_q <= res_anc_d;
    res_st_q  <= res_st_d;
    cnt_q     <= cnt_d;
    head_q    <= head_d;
    tail_q    <= tail_d;
    e_q       <= e_d;
    v_q       <= v_d;
    u_q       <= u_d;
    side_q    <= side_d;
    lnk_q     <= lnk_d;
    row_q     <= row_d;
    j_q       <= j_d;
    qa_q      <= qa_d;
    qb_q      <= qb_d;
    lv_q      <= lv_d;
    la_q      <= la_d;
    da_q      <= da_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    k_q       <= k_d;
  end

endmodule

>>> rtl/tlbl_checker.sv
// Port-level checker for the tree ancestor engine, bound to the top level.
module tlbl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [1:0] kind_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [9:0] ancestor_o,
  input logic [1:0] status_o
);
  import tlbl_pkg::*;

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_OK || status_o == ST_RANGE || status_o == ST_UNBUILT))
    else $error("undefined status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> ancestor_o == '0)
    else $error("error result carries a nonzero ancestor");

  // A build always runs a clearing sweep, so the input side is busy next cycle.
  a_build_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && kind_i == KIND_BUILD |=> in_stall_o)
    else $error("build finished without a sweep");

endmodule

bind tree_lca_binary_lifting tlbl_checker u_tlbl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .kind_i      (kind_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .ancestor_o  (ancestor_o),
  .status_o    (status_o)
);

>>> tb/tb_top.sv
// Self-checking testbench for the lowest-common-ancestor engine with a built-in tree predictor.
`timescale 1ns / 1ps

module tb_top;
  import tlbl_pkg::*;

  class lca_scoreboard;
    bit [10:0] node_cnt;
    bit [9:0]  link_a [EdgeCap];
    bit [9:0]  link_b [EdgeCap];
    int        link_total;
    bit [9:0]  jump [MaxNodes][Levels];
    bit [10:0] depth [MaxNodes];
    bit        seen [MaxNodes];
    int        walk [MaxNodes];
    bit        built;
    bit [9:0]  want_anc [$];
    status_e   want_st [$];
    int        fails;

    function new();
      node_cnt   = 11'd1024;
      link_total = 0;
      built      = 1'b0;
      fails      = 0;
      foreach (jump[i, j]) jump[i][j] = '0;
      foreach (depth[i]) begin
        depth[i] = '0;
        seen[i]  = 1'b0;
      end
    endfunction

    function int active();
      if (node_cnt < 1) return 1;
      if (node_cnt > MaxNodes) return MaxNodes;
      return node_cnt;
    endfunction

    function int lift(int v, int unsigned k);
      for (int j = 0; j < 32; j++) begin
        if (k[j]) begin
          if (j < Levels && v < MaxNodes) v = jump[v][j];
          else v = 0;
        end
      end
      return v;
    endfunction

    function void visit(int u, int v, ref int tail);
      if (seen[u]) return;
      seen[u]    = 1'b1;
      depth[u]   = depth[v] + 11'd1;
      jump[u][0] = 10'(v);
      for (int j = 1; j < Levels; j++) jump[u][j] = jump[jump[u][j-1]][j-1];
      if (tail < MaxNodes) begin
        walk[tail] = u;
        tail++;
      end
    endfunction

    function void build_tables();
      int n, head, tail, v;
      n = active();
      head = 0;
      tail = 0;
      foreach (jump[i, j]) jump[i][j] = '0;
      foreach (depth[i]) begin
        depth[i] = '0;
        seen[i]  = 1'b0;
      end
      seen[0]  = 1'b1;
      depth[0] = 11'd1;
      walk[tail++] = 0;
      while (head < tail) begin
        v = walk[head++];
        for (int e = 0; e < link_total; e++) begin
          if (link_a[e] == v && link_b[e] < n) visit(link_b[e], v, tail);
          if (link_b[e] == v && link_a[e] < n) visit(link_a[e], v, tail);
        end
      end
      built = 1'b1;
    endfunction

    function int ancestor_of(int a, int b);
      int lo, hi, mid, t;
      lo = 0;
      hi = active();
      if (depth[a] > depth[b]) begin
        t = a;
        a = b;
        b = t;
      end
      b = lift(b, depth[b] - depth[a]);
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (lift(a, mid) == lift(b, mid)) hi = mid;
        else lo = mid + 1;
      end
      return lift(a, lo);
    endfunction

    function void add_want(bit [9:0] anc, status_e st);
      want_anc.insert(want_anc.size(), anc);
      want_st.insert(want_st.size(), st);
    endfunction

    function void note_transfer(kind_e kind, bit [9:0] a, bit [9:0] b);
      int n;
      case (kind)
        KIND_CLEAR: link_total = 0;
        KIND_ADD: begin
          if (link_total < EdgeCap) begin
            link_a[link_total] = a;
            link_b[link_total] = b;
            link_total++;
          end
        end
        KIND_BUILD: build_tables();
        default: begin
          n = active();
          if (a >= n || b >= n) begin
            add_want('0, ST_RANGE);
          end else if (!built) begin
            add_want('0, ST_UNBUILT);
          end else begin
            add_want(10'(ancestor_of(a, b)), ST_OK);
          end
        end
      endcase
    endfunction

    function void check_result(bit [9:0] anc, bit [1:0] st);
      bit [9:0] ea;
      status_e  es;
      if (want_st.size() == 0) begin
        $display("%0t: unexpected result ancestor=%0d status=%0d", $time, anc, st);
        fails++;
        return;
      end
      ea = want_anc.pop_front();
      es = want_st.pop_front();
      if (st != es) begin
        $display("%0t: status expected %0d actual %0d", $time, es, st);
        fails++;
      end
      if (anc != ea) begin
        $display("%0t: ancestor expected %0d actual %0d", $time, ea, anc);
        fails++;
      end
    endfunction

    function int pending();
      return want_st.size();
    endfunction
  endclass

  localparam int IdleLimit = 200000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] kind_i = '0;
  logic [9:0] node_a_i = '0;
  logic [9:0] node_b_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [9:0] ancestor_o;
  logic [1:0] status_o;

  lca_scoreboard sb = new();
  bit  send_quiet;
  bit  recv_quiet;
  int  stall_left;
  bit  stall_now;
  int  idle_cycles;
  int  ids [32];

  tree_lca_binary_lifting dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .kind_i, .node_a_i, .node_b_i,
    .out_valid_o, .out_stall_i, .ancestor_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver stall pattern: runs of free cycles and runs of stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_now  = !recv_quiet && ($urandom_range(0, 99) < 35);
      stall_left = stall_now ? pick_gap() + 1 : $urandom_range(1, 8);
    end
    stall_left--;
    out_stall_i <= stall_now;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(ancestor_o, status_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("tree_lca_binary_lifting: mismatch");
      $finish;
    end
  end

  task automatic send(kind_e kind, bit [9:0] a, bit [9:0] b);
    int g;
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    node_a_i   <= a;
    node_b_i   <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_transfer(kind, a, b);
    g = send_quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // A trailing query marks the point where the engine has gone idle.
  task automatic settle();
    send(KIND_QUERY, 10'd0, 10'd0);
    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_count(bit [10:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.node_cnt = v;
    @(posedge clk_i);
  endtask

  task automatic random_phase(bit [10:0] cnt);
    int n, sz, q, r, x, y;
    set_count(cnt);
    n = sb.active();
    send_quiet = ($urandom_range(0, 3) == 0);
    recv_quiet = ($urandom_range(0, 3) == 0);
    sz = (n < 24) ? n : $urandom_range(2, 24);
    ids[0] = 0;
    for (int i = 1; i < sz; i++) begin
      ids[i] = (n <= 32) ? i : $urandom_range(1, n - 1);
    end
    send(KIND_CLEAR, 10'($urandom), 10'($urandom));
    for (int i = 1; i < sz; i++) begin
      x = ids[$urandom_range(0, i - 1)];
      if ($urandom_range(0, 1)) send(KIND_ADD, 10'(x), 10'(ids[i]));
      else send(KIND_ADD, 10'(ids[i]), 10'(x));
    end
    repeat ($urandom_range(0, 4)) send(KIND_ADD, 10'($urandom), 10'($urandom));
    send(KIND_BUILD, 10'($urandom), 10'($urandom));
    q = $urandom_range(28, 38);
    for (int i = 0; i < q; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        x = ids[$urandom_range(0, sz - 1)];
        y = ids[$urandom_range(0, sz - 1)];
      end else if (r < 92) begin
        x = $urandom_range(0, n - 1);
        y = $urandom_range(0, n - 1);
      end else begin
        x = $urandom_range(0, 1023);
        y = $urandom_range(0, 1023);
      end
      send(KIND_QUERY, 10'(x), 10'(y));
      // Occasional edge edits without a rebuild leave the tables stale.
      if ($urandom_range(0, 99) < 4) begin
        send(KIND_ADD, 10'(ids[$urandom_range(0, sz - 1)]), 10'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unbuilt tables, range before unbuilt, a small tree.
    send(KIND_QUERY, 10'd5, 10'd3);
    settle();
    set_count(11'd4);
    send(KIND_QUERY, 10'd9, 10'd1);
    send(KIND_ADD, 10'd0, 10'd1);
    send(KIND_ADD, 10'd2, 10'd1);
    send(KIND_ADD, 10'd2, 10'd3);
    send(KIND_ADD, 10'd0, 10'd9);
    send(KIND_ADD, 10'd3, 10'd1);
    send(KIND_BUILD, 10'd0, 10'd0);
    send(KIND_QUERY, 10'd3, 10'd2);
    send(KIND_QUERY, 10'd3, 10'd0);
    send(KIND_QUERY, 10'd2, 10'd2);
    send(KIND_QUERY, 10'd0, 10'd3);
    send(KIND_QUERY, 10'd1023, 10'd1023);
    send(KIND_CLEAR, 10'd1023, 10'd1023);
    send(KIND_QUERY, 10'd3, 10'd1);
    send(KIND_ADD, 10'd1, 10'd3);
    send(KIND_QUERY, 10'd1, 10'd3);
    settle();

    random_phase(11'd1);
    random_phase(11'd0);
    random_phase(11'd2);
    random_phase(11'd7);
    random_phase(11'd16);
    random_phase(11'd1024);
    random_phase(11'd33);
    random_phase(11'd2047);
    random_phase(11'd100);
    random_phase(11'd1024);

    in_valid_i <= 1'b0;
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("tree_lca_binary_lifting: match");
    end else begin
      $display("tree_lca_binary_lifting: mismatch");
    end
    $finish;
  end
endmodule
